@@ sv/ifhc_pkg.sv @@
// Shared types, constants and the ones-complement adder for the IPv4 flow header checker.
// No dependencies.
`default_nettype none

package ifhc_pkg;

  typedef enum logic [1:0] {
    LINK_ETH    = 2'd0,
    LINK_LOOP   = 2'd1,
    LINK_COOKED = 2'd2,
    LINK_OTHER  = 2'd3
  } link_kind_t;

  // Configuration register indexes
  localparam logic REG_LINK_KIND     = 1'b0;
  localparam logic REG_LENGTH_SOURCE = 1'b1;

  localparam int LINK_LEN_ETH    = 14;
  localparam int LINK_LEN_LOOP   = 4;
  localparam int LINK_LEN_COOKED = 16;

  localparam int ETH_TYPE_HI_OFF = 12;
  localparam int ETH_TYPE_LO_OFF = 13;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

  // Per-frame record carried down the finish pipeline
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] len;
    logic [7:0]  proto;
    logic [31:0] ports;
    logic [15:0] stored_seg;
    logic        hdr_ok;
  } flow_rec_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

`default_nettype wire

@@ sv/ipv4_flow_header_checker.sv @@
// IPv4 flow header checker: byte-wise header parse, checksum verify and flow report.
// Depends on ifhc_pkg (types, constants, oc_add).
//
// Usage: frame bytes enter on the in_valid/in_ready channel, one byte per request,
// last_byte marking the end of the frame; wire_length is sampled with the last byte.
// Each frame yields at most one result request on out_valid/out_ready carrying
// addresses, length, protocol and ports. Frames with a bad header checksum, a
// header shorter than five words, a non-IPv4 ethertype or link kind "other" give
// no result.
// Throughput: one byte per cycle, except while a last byte waits for the finish
// pipeline; set by the per-byte offset decode and the ones-complement add into the
// running sums, both combinational. After the last byte the result passes the input
// register, frame snapshot, partial sums, final sum and result register in that order.
// Reset clears all frame state and sets link_kind and length_source to zero.
// When the receiver stalls, the result holds in the output register and bytes
// keep flowing; a following last byte waits only once the three finish stages
// behind the output register are full.
// Configuration: write cfg_data to register cfg_index while cfg_write_en is high,
// only while no frame is in progress.
`default_nettype none

module ipv4_flow_header_checker #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] wire_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      src_address,
  output logic [31:0]      dst_address,
  output logic [15:0]      reported_length,
  output logic [7:0]       protocol,
  output logic [15:0]      src_port,
  output logic [15:0]      dst_port
);

  localparam int OB = OFFSET_BITS;
  localparam int CW = (OB > 16) ? OB : 16;

  // Configuration
  ifhc_pkg::link_kind_t link_kind;
  logic                 length_source;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_kind     <= ifhc_pkg::LINK_ETH;
      length_source <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ifhc_pkg::REG_LINK_KIND:     link_kind     <= ifhc_pkg::link_kind_t'(cfg_data);
        ifhc_pkg::REG_LENGTH_SOURCE: length_source <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  logic        r_valid;
  logic [7:0]  r_byte;
  logic        r_last;
  logic [15:0] r_wire;
  logic        r_go;

  // Frame state
  logic [OB-1:0] byte_offset,        byte_offset_next;
  logic [15:0]   seen_ethertype,     seen_ethertype_next;
  logic [3:0]    header_words,       header_words_next;
  logic [15:0]   total_len_field,    total_len_field_next;
  logic [7:0]    proto_field,        proto_field_next;
  logic [31:0]   captured_src,       captured_src_next;
  logic [31:0]   captured_dst,       captured_dst_next;
  logic [15:0]   header_sum,         header_sum_next;
  logic [15:0]   stored_header_sum,  stored_header_sum_next;
  logic [15:0]   segment_sum,        segment_sum_next;
  logic [15:0]   stored_segment_sum, stored_segment_sum_next;
  logic [31:0]   captured_ports,     captured_ports_next;

  // Finish pipeline
  logic                f1_valid, f2_valid, f3_valid;
  ifhc_pkg::flow_rec_t f1_rec, f2_rec, f3_rec;
  logic [3:0]          f1_hw;
  logic [15:0]         f1_hsum, f1_stored_hsum, f1_segsum, f1_total;
  logic [17:0]         f2_p1, f2_p2;
  logic [15:0]         f2_seg_len;
  logic [18:0]         f3_sum;
  logic                o_free, f3_free, f2_free, f1_free;

  assign o_free   = !out_valid || out_ready;
  assign f3_free  = !f3_valid || o_free;
  assign f2_free  = !f2_valid || f3_free;
  assign f1_free  = !f1_valid || f2_free;
  assign r_go     = r_valid && (!r_last || f1_free);
  assign in_ready = !r_valid || r_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_ready) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r_byte <= data_byte;
      r_last <= last_byte;
      r_wire <= wire_length;
    end
  end

  // Per-byte decode
  logic [OB-1:0] lnk_len, hdr_off, hlen, seg_off;
  logic          sat, in_hdr, in_ip;
  logic [15:0]   word_part, seg_len_b;

  always_comb begin
    case (link_kind)
      ifhc_pkg::LINK_ETH:  lnk_len = OB'(ifhc_pkg::LINK_LEN_ETH);
      ifhc_pkg::LINK_LOOP: lnk_len = OB'(ifhc_pkg::LINK_LEN_LOOP);
      default:             lnk_len = OB'(ifhc_pkg::LINK_LEN_COOKED);
    endcase

    byte_offset_next        = byte_offset;
    seen_ethertype_next     = seen_ethertype;
    header_words_next       = header_words;
    total_len_field_next    = total_len_field;
    proto_field_next        = proto_field;
    captured_src_next       = captured_src;
    captured_dst_next       = captured_dst;
    header_sum_next         = header_sum;
    stored_header_sum_next  = stored_header_sum;
    segment_sum_next        = segment_sum;
    stored_segment_sum_next = stored_segment_sum;
    captured_ports_next     = captured_ports;

    sat       = &byte_offset;
    in_hdr    = byte_offset >= lnk_len;
    hdr_off   = byte_offset - lnk_len;
    word_part = hdr_off[0] ? {8'h00, r_byte} : {r_byte, 8'h00};

    // Field captures see the values written by this same byte
    if (!sat && in_hdr) begin
      if (hdr_off == OB'(0))  header_words_next          = r_byte[3:0];
      if (hdr_off == OB'(2))  total_len_field_next[15:8] = r_byte;
      if (hdr_off == OB'(3))  total_len_field_next[7:0]  = r_byte;
      if (hdr_off == OB'(9))  proto_field_next           = r_byte;
      if (hdr_off == OB'(12)) captured_src_next[31:24]   = r_byte;
      if (hdr_off == OB'(13)) captured_src_next[23:16]   = r_byte;
      if (hdr_off == OB'(14)) captured_src_next[15:8]    = r_byte;
      if (hdr_off == OB'(15)) captured_src_next[7:0]     = r_byte;
      if (hdr_off == OB'(16)) captured_dst_next[31:24]   = r_byte;
      if (hdr_off == OB'(17)) captured_dst_next[23:16]   = r_byte;
      if (hdr_off == OB'(18)) captured_dst_next[15:8]    = r_byte;
      if (hdr_off == OB'(19)) captured_dst_next[7:0]     = r_byte;
    end

    hlen      = {{(OB-6){1'b0}}, header_words_next, 2'b00};
    in_ip     = hdr_off < hlen;
    seg_off   = hdr_off - hlen;
    seg_len_b = total_len_field_next - {10'b0, header_words_next, 2'b00};

    if (!sat) begin
      byte_offset_next = byte_offset + OB'(1);
      if (link_kind == ifhc_pkg::LINK_ETH) begin
        if (byte_offset == OB'(ifhc_pkg::ETH_TYPE_HI_OFF)) seen_ethertype_next[15:8] = r_byte;
        if (byte_offset == OB'(ifhc_pkg::ETH_TYPE_LO_OFF)) seen_ethertype_next[7:0]  = r_byte;
      end
      if (in_hdr) begin
        if (in_ip) begin
          // Header checksum field is held aside and summed as zero
          if (hdr_off == OB'(10))      stored_header_sum_next[15:8] = r_byte;
          else if (hdr_off == OB'(11)) stored_header_sum_next[7:0]  = r_byte;
          else header_sum_next = ifhc_pkg::oc_add(header_sum, word_part);
        end else begin
          if (seg_off < OB'(4)) begin
            case (seg_off[1:0])
              2'd0:    captured_ports_next[31:24] = r_byte;
              2'd1:    captured_ports_next[23:16] = r_byte;
              2'd2:    captured_ports_next[15:8]  = r_byte;
              default: captured_ports_next[7:0]   = r_byte;
            endcase
          end
          // Padding past the segment length stays out of the sum
          if (CW'(seg_off) < CW'(seg_len_b)) begin
            if ((proto_field_next == ifhc_pkg::PROTO_TCP &&
                 (seg_off == OB'(16) || seg_off == OB'(17))) ||
                (proto_field_next == ifhc_pkg::PROTO_UDP &&
                 (seg_off == OB'(6) || seg_off == OB'(7)))) begin
              if (seg_off[0]) stored_segment_sum_next[7:0]  = r_byte;
              else            stored_segment_sum_next[15:8] = r_byte;
            end else begin
              segment_sum_next = ifhc_pkg::oc_add(segment_sum, word_part);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (r_go && r_last)) begin
      byte_offset        <= '0;
      seen_ethertype     <= '0;
      header_words       <= '0;
      total_len_field    <= '0;
      proto_field        <= '0;
      captured_src       <= '0;
      captured_dst       <= '0;
      header_sum         <= '0;
      stored_header_sum  <= '0;
      segment_sum        <= '0;
      stored_segment_sum <= '0;
      captured_ports     <= '0;
    end else if (r_go) begin
      byte_offset        <= byte_offset_next;
      seen_ethertype     <= seen_ethertype_next;
      header_words       <= header_words_next;
      total_len_field    <= total_len_field_next;
      proto_field        <= proto_field_next;
      captured_src       <= captured_src_next;
      captured_dst       <= captured_dst_next;
      header_sum         <= header_sum_next;
      stored_header_sum  <= stored_header_sum_next;
      segment_sum        <= segment_sum_next;
      stored_segment_sum <= stored_segment_sum_next;
      captured_ports     <= captured_ports_next;
    end
  end

  // Stage F1: snapshot of the finished frame, link, ethertype and header length checks
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_free) begin
      f1_valid <= r_go && r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_free) begin
      f1_rec.src        <= captured_src_next;
      f1_rec.dst        <= captured_dst_next;
      f1_rec.len        <= length_source ? total_len_field_next : r_wire;
      f1_rec.proto      <= proto_field_next;
      f1_rec.ports      <= captured_ports_next;
      f1_rec.stored_seg <= stored_segment_sum_next;
      f1_rec.hdr_ok     <= (link_kind != ifhc_pkg::LINK_OTHER) &&
                           (link_kind != ifhc_pkg::LINK_ETH ||
                            seen_ethertype_next == ifhc_pkg::ETHERTYPE_IPV4) &&
                           (header_words_next >= ifhc_pkg::MIN_HDR_WORDS);
      f1_hw             <= header_words_next;
      f1_hsum           <= header_sum_next;
      f1_stored_hsum    <= stored_header_sum_next;
      f1_segsum         <= segment_sum_next;
      f1_total          <= total_len_field_next;
    end
  end

  // Stage F2: header verdict and partial pseudo-header sums
  logic hdr_ok;

  assign hdr_ok = f1_rec.hdr_ok && ((~f1_hsum) == f1_stored_hsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (f2_free) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_free) begin
      f2_rec        <= {f1_rec.src, f1_rec.dst, f1_rec.len, f1_rec.proto, f1_rec.ports,
                        f1_rec.stored_seg, hdr_ok};
      f2_p1         <= {2'b0, f1_segsum} + {2'b0, f1_rec.src[31:16]} +
                       {2'b0, f1_rec.src[15:0]};
      f2_p2         <= {2'b0, f1_rec.dst[31:16]} + {2'b0, f1_rec.dst[15:0]} +
                       {10'b0, f1_rec.proto};
      f2_seg_len    <= f1_total - {10'b0, f1_hw, 2'b00};
    end
  end

  // Stage F3: full pseudo-header plus segment sum, carries not yet folded
  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (f3_free) begin
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f3_free) begin
      f3_rec <= f2_rec;
      f3_sum <= {1'b0, f2_p1} + {1'b0, f2_p2} + {3'b0, f2_seg_len};
    end
  end

  // Fold, L4 verdict and result register
  logic [16:0] fold1;
  logic [15:0] l4_sum;
  logic        is_tcp_udp, l4_good;

  assign fold1      = {1'b0, f3_sum[15:0]} + {14'b0, f3_sum[18:16]};
  assign l4_sum     = fold1[15:0] + {15'b0, fold1[16]};
  assign is_tcp_udp = (f3_rec.proto == ifhc_pkg::PROTO_TCP) ||
                      (f3_rec.proto == ifhc_pkg::PROTO_UDP);
  assign l4_good    = (~l4_sum) == f3_rec.stored_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= f3_valid && f3_rec.hdr_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      src_address     <= f3_rec.src;
      dst_address     <= f3_rec.dst;
      reported_length <= f3_rec.len;
      protocol        <= (is_tcp_udp && !l4_good) ? 8'h00 : f3_rec.proto;
      src_port        <= (is_tcp_udp && l4_good) ? f3_rec.ports[31:16] : 16'h0000;
      dst_port        <= (is_tcp_udp && l4_good) ? f3_rec.ports[15:0] : 16'h0000;
    end
  end

  // Checks
  a_ready_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (r_valid && r_last && f1_valid))
    else $error("input stalled without a pending last byte");

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (r_go && r_last) |=> (byte_offset == '0 && header_words == '0))
    else $error("frame state not cleared after last byte");

  a_offset_advances: assert property (@(posedge clk) disable iff (rst)
    (r_go && !r_last && !(&byte_offset)) |=> byte_offset == $past(byte_offset) + OB'(1))
    else $error("byte offset did not advance");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(f3_valid && f3_rec.hdr_ok))
    else $error("result without a verified frame");

endmodule

`default_nettype wire
